// ===== src/grc_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the grid ray caster.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package grc_pkg;

  localparam int MAP_WIDTH  = 32;
  localparam int MAP_HEIGHT = 32;
  localparam int ANGLE_BITS = 10;

  localparam int CELLS     = MAP_WIDTH * MAP_HEIGHT;
  localparam int CELL_BITS = $clog2(CELLS);
  localparam int X_BITS    = $clog2(MAP_WIDTH);
  localparam int Y_BITS    = $clog2(MAP_HEIGHT);
  localparam int AXIS_BITS = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;

  localparam int QUARTER_BITS = ANGLE_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;

  localparam int POSE_BITS  = 13;
  localparam int REG_BITS   = 10;
  localparam int INDEX_BITS = 10;
  localparam int COL_BITS   = 10;
  localparam int ROW_BITS   = 16;
  localparam int SHADE_BITS = 8;

  localparam int SINE_BITS = 17;
  localparam int DIR_BITS  = SINE_BITS + 1;
  localparam int POS_BITS  = 29;
  localparam int FRAC_BITS = 16;
  localparam int Q_BITS    = POS_BITS - 1 - FRAC_BITS;
  localparam int ORIGIN_SCALE = 2560;
  localparam int CELL_UNIT    = 655360;
  localparam int CELL_DIV     = CELL_UNIT >> FRAC_BITS;
  localparam int RECIP_BITS   = 13;
  localparam int RECIP        = 6554;
  localparam int RECIP_SHIFT  = 16;

  localparam int STEP_BITS = REG_BITS + 1;
  localparam int NEAR_BIAS = 20;

  localparam int DIV_N_BITS   = 21;
  localparam int DIV_D_BITS   = 11;
  localparam int DIV_CNT_BITS = $clog2(DIV_N_BITS + 1);

  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [SHADE_BITS-1:0] SHADE_NEAR = 8'd255;
  localparam logic [SHADE_BITS-1:0] SHADE_MID  = 8'd200;
  localparam logic [SHADE_BITS-1:0] SHADE_FAR  = 8'd150;
  localparam logic [SHADE_BITS-1:0] SHADE_DIM  = 8'd100;
  localparam logic [SHADE_BITS-1:0] SHADE_NONE = 8'd0;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_POSE_X         = 3'd0,
    CFG_POSE_Y         = 3'd1,
    CFG_POSE_ANGLE     = 3'd2,
    CFG_FIELD_OF_VIEW  = 3'd3,
    CFG_SCREEN_COLUMNS = 3'd4,
    CFG_SCREEN_ROWS    = 3'd5,
    CFG_STEP_LIMIT     = 3'd6
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ANGLE_MUL,
    ST_ANGLE_GO,
    ST_ANGLE_WAIT,
    ST_DIR,
    ST_MARCH_GO,
    ST_MARCH,
    ST_CEIL_MUL,
    ST_CEIL_GO,
    ST_CEIL_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear_run;
    logic write_cell;
    logic take_cast;
    logic angle_mul;
    logic div_start;
    logic dir_load;
    logic march_start;
    logic march_run;
    logic ceil_mul;
    logic load_result;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_busy;
    logic march_done;
  } dp_status_t;

  typedef logic [SINE_BITS-1:0] sine_table_t [0:QUARTER];

  function automatic sine_table_t build_sine_table();
    sine_table_t tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    for (int r = 0; r <= QUARTER; r++) begin
      x  = 64'(r) << (16 - QUARTER_BITS);
      x2 = (x * x) >> 16;
      t  = 64'd307;
      t  = 64'd5223 - ((t * x2) >> 16);
      t  = 64'd42334 - ((t * x2) >> 16);
      t  = 64'd102944 - ((t * x2) >> 16);
      s  = (t * x) >> 16;
      if (s > 64'd65536) s = 64'd65536;
      tab[r] = SINE_BITS'(s);
    end
    return tab;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// ===== src/grc_if.sv =====
// Valid/ready channel interfaces for request items and result items.
// Depends on grc_pkg for field widths.
`timescale 1ns / 1ps

interface grc_request_if;
  import grc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [INDEX_BITS-1:0] cell_index;
  logic                  cell_wall;
  logic [COL_BITS-1:0]   column;
  modport source (output valid, operation, cell_index, cell_wall, column, input ready);
  modport sink (input valid, operation, cell_index, cell_wall, column, output ready);
endinterface

interface grc_result_if;
  import grc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       wall_hit;
  logic [REG_BITS-1:0]        distance_steps;
  logic signed [ROW_BITS-1:0] ceiling_row;
  logic signed [ROW_BITS-1:0] floor_row;
  logic [SHADE_BITS-1:0]      shade;
  modport source (output valid, wall_hit, distance_steps, ceiling_row, floor_row, shade,
                  input ready);
  modport sink (input valid, wall_hit, distance_steps, ceiling_row, floor_row, shade,
                output ready);
endinterface

// ===== src/grid_raycast_column_unit.sv =====
// Grid ray caster for one screen column: a cast of a ray stopping at step k (k <= the
// step limit, or 1 when the limit is 0) takes one map lookup per step and two serial
// divisions (view angle, ceiling row).
// One item is in work at a time; a result may wait while the next item is taken.
// Reset (rst, synchronous) restores the registers and sweeps the 1024-cell map
// clear, one cell a cycle, with request.ready low during the sweep.
`timescale 1ns / 1ps

module grid_raycast_column_unit (
  input  logic                              clk,
  input  logic                              rst,
  grc_request_if.sink                       request,
  grc_result_if.source                      result,
  input  logic                              cfg_write,
  input  grc_pkg::cfg_index_t               cfg_index,
  input  logic [grc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import grc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  grc_controller u_controller (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (request.valid),
    .in_operation (request.operation),
    .in_ready     (request.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  grc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_cell_index  (request.cell_index),
    .in_cell_wall   (request.cell_wall),
    .in_column      (request.column),
    .cmd            (cmd),
    .status         (status),
    .wall_hit       (result.wall_hit),
    .distance_steps (result.distance_steps),
    .ceiling_row    (result.ceiling_row),
    .floor_row      (result.floor_row),
    .shade          (result.shade)
  );

endmodule

// ===== src/grc_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on grc_pkg for operand widths.
`timescale 1ns / 1ps

module grc_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [grc_pkg::DIV_N_BITS-1:0]  dividend,
  input  logic [grc_pkg::DIV_D_BITS-1:0]  divisor,
  output logic                            busy,
  output logic [grc_pkg::DIV_N_BITS-1:0]  quotient
);
  import grc_pkg::*;

  logic [DIV_D_BITS-1:0]   rem;
  logic [DIV_N_BITS-1:0]   quo;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [DIV_D_BITS:0]     trial;
  logic                    fits;

  assign trial    = {rem, quo[DIV_N_BITS-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_BITS'(DIV_N_BITS);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= cnt != DIV_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? DIV_D_BITS'(trial - {1'b0, divisor}) : DIV_D_BITS'(trial);
      quo <= {quo[DIV_N_BITS-2:0], fits};
    end
  end

endmodule

// ===== src/grc_datapath.sv =====
// Datapath: configuration registers, wall map memory, angle and row divider,
// sine lookup, ray march pipeline and result registers. Depends on grc_pkg, grc_divider.
`timescale 1ns / 1ps

module grc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  grc_pkg::cfg_index_t                 cfg_index,
  input  logic [grc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic [grc_pkg::INDEX_BITS-1:0]      in_cell_index,
  input  logic                                in_cell_wall,
  input  logic [grc_pkg::COL_BITS-1:0]        in_column,
  input  grc_pkg::dp_cmd_t                    cmd,
  output grc_pkg::dp_status_t                 status,
  output logic                                wall_hit,
  output logic [grc_pkg::REG_BITS-1:0]        distance_steps,
  output logic signed [grc_pkg::ROW_BITS-1:0] ceiling_row,
  output logic signed [grc_pkg::ROW_BITS-1:0] floor_row,
  output logic [grc_pkg::SHADE_BITS-1:0]      shade
);
  import grc_pkg::*;

  typedef struct packed {
    logic                 off;
    logic [AXIS_BITS-1:0] idx;
  } axis_t;

  function automatic logic signed [DIR_BITS-1:0] sine_dir(input logic [ANGLE_BITS-1:0] a);
    logic [1:0]              quad;
    logic [QUARTER_BITS-1:0] r;
    logic [QUARTER_BITS:0]   idx;
    logic [SINE_BITS-1:0]    mag;
    quad = a[ANGLE_BITS-1:ANGLE_BITS-2];
    r    = a[QUARTER_BITS-1:0];
    idx  = quad[0] ? (QUARTER_BITS+1)'(QUARTER - int'(r)) : {1'b0, r};
    mag  = SINE_TABLE[idx];
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic axis_t locate(input logic signed [POS_BITS-1:0] num,
                                   input logic [Q_BITS-1:0] q_limit);
    axis_t                         res;
    logic [Q_BITS-1:0]             q;
    logic [Q_BITS+RECIP_BITS-1:0]  scaled;
    q      = num[POS_BITS-2:FRAC_BITS];
    scaled = (Q_BITS+RECIP_BITS)'(q) * (Q_BITS+RECIP_BITS)'(RECIP);
    res    = '0;
    if (num <= -CELL_UNIT) begin
      res.off = 1'b1;
    end else if (num < 0) begin
      res.idx = '0;
    end else if (q >= q_limit) begin
      res.off = 1'b1;
    end else begin
      res.idx = AXIS_BITS'(scaled >> RECIP_SHIFT);
    end
    return res;
  endfunction

  logic [POSE_BITS-1:0] pose_x;
  logic [POSE_BITS-1:0] pose_y;
  logic [REG_BITS-1:0]  pose_angle;
  logic [REG_BITS-1:0]  field_of_view;
  logic [REG_BITS-1:0]  screen_columns;
  logic [REG_BITS-1:0]  screen_rows;
  logic [REG_BITS-1:0]  step_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x         <= POSE_BITS'(2048);
      pose_y         <= POSE_BITS'(2048);
      pose_angle     <= '0;
      field_of_view  <= REG_BITS'(256);
      screen_columns <= REG_BITS'(320);
      screen_rows    <= REG_BITS'(240);
      step_limit     <= REG_BITS'(320);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_POSE_X:         pose_x         <= cfg_data;
        CFG_POSE_Y:         pose_y         <= cfg_data;
        CFG_POSE_ANGLE:     pose_angle     <= cfg_data[REG_BITS-1:0];
        CFG_FIELD_OF_VIEW:  field_of_view  <= cfg_data[REG_BITS-1:0];
        CFG_SCREEN_COLUMNS: screen_columns <= cfg_data[REG_BITS-1:0];
        CFG_SCREEN_ROWS:    screen_rows    <= cfg_data[REG_BITS-1:0];
        CFG_STEP_LIMIT:     step_limit     <= cfg_data[REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [REG_BITS-1:0] cols_eff;
  logic [REG_BITS-1:0] limit_eff;
  assign cols_eff  = (screen_columns == '0) ? REG_BITS'(1) : screen_columns;
  assign limit_eff = (step_limit == '0) ? REG_BITS'(1) : step_limit;

  // wall map with clearing sweep
  logic                 wall_mem [CELLS];
  logic [CELL_BITS-1:0] clr_cnt;
  logic [CELL_BITS-1:0] rd_addr;
  logic                 rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_run) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_run) begin
      wall_mem[clr_cnt] <= 1'b0;
    end else if (cmd.write_cell && (int'(in_cell_index) < CELLS)) begin
      wall_mem[CELL_BITS'(in_cell_index)] <= in_cell_wall;
    end
    rd_data <= wall_mem[rd_addr];
  end

  // divider operands
  logic [COL_BITS-1:0]         column_r;
  logic [DIV_N_BITS-1:0]       div_num;
  logic [DIV_D_BITS-1:0]       div_den;
  logic [DIV_N_BITS-1:0]       quot;
  logic                        ceil_neg;
  logic signed [REG_BITS:0]    k_off;
  logic signed [2*REG_BITS+1:0] ceil_prod;
  logic [REG_BITS-1:0]         k_final;

  assign k_off     = $signed({1'b0, k_final}) - (REG_BITS+1)'(NEAR_BIAS);
  assign ceil_prod = $signed({1'b0, screen_rows}) * k_off;

  always_ff @(posedge clk) begin
    if (cmd.take_cast) column_r <= in_column;
    if (cmd.angle_mul) begin
      div_num <= DIV_N_BITS'(column_r) * DIV_N_BITS'(field_of_view);
      div_den <= DIV_D_BITS'(cols_eff);
    end else if (cmd.ceil_mul) begin
      ceil_neg <= ceil_prod[2*REG_BITS+1];
      div_num  <= ceil_prod[2*REG_BITS+1] ? DIV_N_BITS'(-ceil_prod) : DIV_N_BITS'(ceil_prod);
      div_den  <= {k_final, 1'b0};
    end
  end

  grc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (status.div_busy),
    .quotient (quot)
  );

  // ray direction
  logic [DIV_N_BITS-1:0]       angle_sum;
  logic [ANGLE_BITS-1:0]       angle;
  logic signed [DIR_BITS-1:0]  dir_x;
  logic signed [DIR_BITS-1:0]  dir_y;

  assign angle_sum = DIV_N_BITS'(pose_angle) - DIV_N_BITS'(field_of_view >> 1) + quot;
  assign angle     = angle_sum[ANGLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.dir_load) begin
      dir_x <= sine_dir(angle + ANGLE_BITS'(QUARTER));
      dir_y <= sine_dir(angle);
    end
  end

  // march: issue a map read for step k_iss, check step p_k in the next cycle
  logic signed [POS_BITS-1:0] origin_x;
  logic signed [POS_BITS-1:0] origin_y;
  logic signed [POS_BITS-1:0] acc_x;
  logic signed [POS_BITS-1:0] acc_y;
  logic [STEP_BITS-1:0]       k_iss;
  logic [STEP_BITS-1:0]       p_k;
  logic                       p_valid;
  logic                       p_out;
  logic                       hit_r;
  axis_t                      loc_x;
  axis_t                      loc_y;

  assign origin_x = $signed(POS_BITS'(pose_x) * POS_BITS'(ORIGIN_SCALE));
  assign origin_y = $signed(POS_BITS'(pose_y) * POS_BITS'(ORIGIN_SCALE));
  assign loc_x    = locate(acc_x, Q_BITS'(MAP_WIDTH * CELL_DIV));
  assign loc_y    = locate(acc_y, Q_BITS'(MAP_HEIGHT * CELL_DIV));
  assign rd_addr  = CELL_BITS'(int'(loc_y.idx) * MAP_WIDTH + int'(loc_x.idx));

  assign status.clear_last = clr_cnt == CELL_BITS'(CELLS - 1);
  assign status.march_done = p_valid && (p_out || rd_data || p_k == STEP_BITS'(limit_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (cmd.march_start) begin
      p_valid <= 1'b0;
    end else if (cmd.march_run) begin
      p_valid <= !status.march_done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.march_start) begin
      acc_x <= origin_x + POS_BITS'(dir_x);
      acc_y <= origin_y + POS_BITS'(dir_y);
      k_iss <= STEP_BITS'(1);
    end else if (cmd.march_run) begin
      acc_x <= acc_x + POS_BITS'(dir_x);
      acc_y <= acc_y + POS_BITS'(dir_y);
      k_iss <= k_iss + 1'b1;
      p_k   <= k_iss;
      p_out <= loc_x.off || loc_y.off;
      if (status.march_done) begin
        k_final <= p_out ? limit_eff : p_k[REG_BITS-1:0];
        hit_r   <= !p_out && rd_data;
      end
    end
  end

  // result registers
  logic signed [ROW_BITS-1:0] ceil_val;
  logic [REG_BITS+1:0]        k_ext;
  logic [REG_BITS+1:0]        l_ext;
  logic [SHADE_BITS-1:0]      shade_val;

  assign ceil_val = ceil_neg ? -$signed(ROW_BITS'(quot)) : $signed(ROW_BITS'(quot));
  assign k_ext    = (REG_BITS+2)'(k_final);
  assign l_ext    = (REG_BITS+2)'(limit_eff);

  always_comb begin
    priority if ((k_ext << 2) <= l_ext) shade_val = SHADE_NEAR;
    else if (k_ext * 3 < l_ext)         shade_val = SHADE_MID;
    else if ((k_ext << 1) < l_ext)      shade_val = SHADE_FAR;
    else if (k_ext < l_ext)             shade_val = SHADE_DIM;
    else                                shade_val = SHADE_NONE;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      wall_hit       <= hit_r;
      distance_steps <= k_final;
      ceiling_row    <= ceil_val;
      floor_row      <= $signed(ROW_BITS'(screen_rows)) - ceil_val;
      shade          <= shade_val;
    end
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (p_k != '0 && p_k <= STEP_BITS'(limit_eff)))
    else $error("march step outside 1..limit");
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> (k_final != '0 && k_final <= limit_eff))
    else $error("distance outside 1..limit");
  a_march_stop: assert property (@(posedge clk) disable iff (rst)
    cmd.march_run && status.march_done |=> !p_valid)
    else $error("march kept checking after stop");
`endif

endmodule

// ===== src/grc_controller.sv =====
// Controller: sequences map clearing, map writes and column casts over the datapath.
// Depends on grc_pkg for the state, command and status types.
`timescale 1ns / 1ps

module grc_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_operation,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  grc_pkg::dp_status_t status,
  output grc_pkg::dp_cmd_t    cmd
);
  import grc_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = state == ST_IDLE;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:      if (status.clear_last) state_next = ST_IDLE;
      ST_IDLE:       if (accept && in_operation == OP_CAST) state_next = ST_ANGLE_MUL;
      ST_ANGLE_MUL:  state_next = ST_ANGLE_GO;
      ST_ANGLE_GO:   state_next = ST_ANGLE_WAIT;
      ST_ANGLE_WAIT: if (!status.div_busy) state_next = ST_DIR;
      ST_DIR:        state_next = ST_MARCH_GO;
      ST_MARCH_GO:   state_next = ST_MARCH;
      ST_MARCH:      if (status.march_done) state_next = ST_CEIL_MUL;
      ST_CEIL_MUL:   state_next = ST_CEIL_GO;
      ST_CEIL_GO:    state_next = ST_CEIL_WAIT;
      ST_CEIL_WAIT:  if (!status.div_busy) state_next = ST_FINISH;
      ST_FINISH:     if (!out_valid || out_ready) state_next = ST_IDLE;
      default:       state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_CLEAR:    cmd.clear_run = 1'b1;
      ST_IDLE: begin
        cmd.write_cell = accept && in_operation == OP_WRITE;
        cmd.take_cast  = accept && in_operation == OP_CAST;
      end
      ST_ANGLE_MUL: cmd.angle_mul   = 1'b1;
      ST_ANGLE_GO:  cmd.div_start   = 1'b1;
      ST_DIR:       cmd.dir_load    = 1'b1;
      ST_MARCH_GO:  cmd.march_start = 1'b1;
      ST_MARCH:     cmd.march_run   = 1'b1;
      ST_CEIL_MUL:  cmd.ceil_mul    = 1'b1;
      ST_CEIL_GO:   cmd.div_start   = 1'b1;
      ST_FINISH:    cmd.load_result = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)                  out_valid <= 1'b0;
    else if (cmd.load_result) out_valid <= 1'b1;
    else if (out_ready)       out_valid <= 1'b0;
  end

`ifndef SYNTHESIS
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside finish");
  a_clear_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |=> (state == ST_CLEAR || state == ST_IDLE))
    else $error("clearing sweep left early");
  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && out_valid && !out_ready |=> state == ST_FINISH && out_valid)
    else $error("finished item dropped while result stalled");
`endif

endmodule

// ===== tb/grid_raycast_column_unit_tb.sv =====
// Self-checking testbench for grid_raycast_column_unit: directed and random map writes and
// column casts, with expected results predicted in the bench and checked field by field.
// Depends on grc_pkg and the request/result channel interfaces.
`timescale 1ns / 1ps

module grid_raycast_column_unit_tb;
  import grc_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic                       wall_hit;
    logic [REG_BITS-1:0]        distance_steps;
    logic signed [ROW_BITS-1:0] ceiling_row;
    logic signed [ROW_BITS-1:0] floor_row;
    logic [SHADE_BITS-1:0]      shade;
  } column_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  cfg_index_t cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  grc_request_if request ();
  grc_result_if  result ();

  grid_raycast_column_unit dut (
    .clk(clk), .rst(rst), .request(request.sink), .result(result.source),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // bench copy of block state
  bit wall_cells [CELLS];
  logic [POSE_BITS-1:0] view_x, view_y;
  logic [REG_BITS-1:0] view_angle, view_span, view_cols, view_rows, march_limit;

  column_view_t pending_views [$];
  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 0;

  function automatic longint quarter_wave(int unsigned r);
    longint x, x2, t, s;
    x  = longint'(r) << (16 - QUARTER_BITS);
    x2 = (x * x) >> 16;
    t  = 307;
    t  = 5223 - ((t * x2) >> 16);
    t  = 42334 - ((t * x2) >> 16);
    t  = 102944 - ((t * x2) >> 16);
    s  = (t * x) >> 16;
    if (s > 65536) s = 65536;
    return s;
  endfunction

  function automatic longint sine_wave(logic [ANGLE_BITS-1:0] a);
    int unsigned r;
    r = a[QUARTER_BITS-1:0];
    case (a[ANGLE_BITS-1:QUARTER_BITS])
      2'd0: return quarter_wave(r);
      2'd1: return quarter_wave(QUARTER - r);
      2'd2: return -quarter_wave(r);
      default: return -quarter_wave(QUARTER - r);
    endcase
  endfunction

  function automatic column_view_t cast_column(logic [COL_BITS-1:0] col);
    column_view_t v;
    int unsigned cols, lim, sum, k;
    logic [ANGLE_BITS-1:0] ang;
    longint dx, dy, ox, oy, tx, ty, rows, ceil_row;
    bit hit;
    cols = (view_cols == 0) ? 1 : view_cols;
    lim  = (march_limit == 0) ? 1 : march_limit;
    sum  = view_angle - (view_span >> 1) + (col * view_span) / cols;
    ang  = sum[ANGLE_BITS-1:0];
    dx   = sine_wave(ang + ANGLE_BITS'(QUARTER));
    dy   = sine_wave(ang);
    ox   = longint'(view_x) * ORIGIN_SCALE;
    oy   = longint'(view_y) * ORIGIN_SCALE;
    hit  = 1'b0;
    k    = 0;
    while (k < lim) begin
      k++;
      tx = (ox + dx * longint'(k)) / CELL_UNIT;
      ty = (oy + dy * longint'(k)) / CELL_UNIT;
      if (tx < 0 || tx >= MAP_WIDTH || ty < 0 || ty >= MAP_HEIGHT) begin
        k = lim;
        break;
      end
      if (wall_cells[ty * MAP_WIDTH + tx]) begin
        hit = 1'b1;
        break;
      end
    end
    rows     = view_rows;
    ceil_row = (rows * (longint'(k) - NEAR_BIAS)) / (2 * longint'(k));
    v.wall_hit       = hit;
    v.distance_steps = k[REG_BITS-1:0];
    v.ceiling_row    = ceil_row[ROW_BITS-1:0];
    v.floor_row      = 16'(rows - ceil_row);
    if (4 * k <= lim)      v.shade = SHADE_NEAR;
    else if (3 * k < lim)  v.shade = SHADE_MID;
    else if (2 * k < lim)  v.shade = SHADE_FAR;
    else if (k < lim)      v.shade = SHADE_DIM;
    else                   v.shade = SHADE_NONE;
    return v;
  endfunction

  // check each accepted result; receiver stalls on its own segmented pattern
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    column_view_t want;
    if (result.valid && result.ready) begin
      if (pending_views.size() == 0) begin
        $error("result with no expected item: distance_steps=%0d", result.distance_steps);
        error_count++;
      end else begin
        want = pending_views.pop_front();
        if (result.wall_hit !== want.wall_hit) begin
          $error("wall_hit exp %0d act %0d", want.wall_hit, result.wall_hit);
          error_count++;
        end
        if (result.distance_steps !== want.distance_steps) begin
          $error("distance_steps exp %0d act %0d", want.distance_steps, result.distance_steps);
          error_count++;
        end
        if (result.ceiling_row !== want.ceiling_row) begin
          $error("ceiling_row exp %0d act %0d", want.ceiling_row, result.ceiling_row);
          error_count++;
        end
        if (result.floor_row !== want.floor_row) begin
          $error("floor_row exp %0d act %0d", want.floor_row, result.floor_row);
          error_count++;
        end
        if (result.shade !== want.shade) begin
          $error("shade exp %0d act %0d", want.shade, result.shade);
          error_count++;
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 80);
    end
    stall_left--;
    case (stall_mode)
      0: result.ready <= 1'b1;
      1: result.ready <= ($urandom_range(0, 1) == 1);
      default: result.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [INDEX_BITS-1:0] idx, logic wall,
                           logic [COL_BITS-1:0] col);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        request.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    request.valid      <= 1'b1;
    request.operation  <= op;
    request.cell_index <= idx;
    request.cell_wall  <= wall;
    request.column     <= col;
    do @(posedge clk); while (!request.ready);
    if (op == OP_CAST) pending_views.push_back(cast_column(col));
    else wall_cells[idx] = wall;
  endtask

  task automatic write_cell(int row, int col_x, logic wall);
    send_item(OP_WRITE, INDEX_BITS'(row * MAP_WIDTH + col_x), wall, COL_BITS'($urandom));
  endtask

  task automatic cast(logic [COL_BITS-1:0] col);
    send_item(OP_CAST, INDEX_BITS'($urandom), 1'($urandom), col);
  endtask

  task automatic wait_idle();
    request.valid <= 1'b0;
    burst_left = 0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all registers back to back; upper spare bits of narrow registers are random
  task automatic set_view(int px, int py, int ang, int span, int cols, int rows, int lim);
    logic [CFG_DATA_BITS-1:0] vals [7];
    vals[0] = CFG_DATA_BITS'(px);
    vals[1] = CFG_DATA_BITS'(py);
    vals[2] = {3'($urandom), 10'(ang)};
    vals[3] = {3'($urandom), 10'(span)};
    vals[4] = {3'($urandom), 10'(cols)};
    vals[5] = {3'($urandom), 10'(rows)};
    vals[6] = {3'($urandom), 10'(lim)};
    for (int i = 0; i < 7; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    view_x = POSE_BITS'(px); view_y = POSE_BITS'(py);
    view_angle = REG_BITS'(ang); view_span = REG_BITS'(span);
    view_cols = REG_BITS'(cols); view_rows = REG_BITS'(rows); march_limit = REG_BITS'(lim);
  endtask

  task automatic test_reset_view();
    cast(10'd0);
    cast(10'd160);
    cast(10'd319);
  endtask

  task automatic test_wall_hits();
    write_cell(8, 12, 1'b1);
    cast(10'd160);
    write_cell(8, 8, 1'b1);
    cast(10'd40);
    write_cell(8, 8, 1'b0);
    write_cell(0, 0, 1'b1);
    write_cell(MAP_HEIGHT - 1, MAP_WIDTH - 1, 1'b1);
    cast(10'd200);
    wait_idle();
  endtask

  task automatic test_view_extremes();
    set_view(0, 0, 512, 1023, 0, 1023, 0);
    cast(10'd0);
    cast(10'd1023);
    wait_idle();
    set_view(8191, 8191, 0, 0, 1023, 1, 1023);
    cast(10'd5);
    cast(10'd1023);
    wait_idle();
    set_view(3, 5000, 768, 512, 1, 500, 1023);
    cast(10'd0);
    cast(10'd1023);
    wait_idle();
    for (int i = 0; i < CELLS; i++) wall_cells[i] = wall_cells[i];
  endtask

  task automatic test_random_scenes(int phases, int items_per_phase);
    int density, lim, cols;
    for (int p = 0; p < phases; p++) begin
      lim  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 160);
      if (p == 0) lim = 1023;
      if (p == 1) lim = 1;
      cols = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 1023);
      set_view($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 1023),
               $urandom_range(0, 1023), cols, $urandom_range(0, 1023), lim);
      density = $urandom_range(2, 30);
      for (int i = 0; i < items_per_phase; i++) begin
        if ($urandom_range(0, 99) < 35)
          send_item(OP_WRITE, INDEX_BITS'($urandom), ($urandom_range(0, 99) < density),
                    COL_BITS'($urandom));
        else if ($urandom_range(0, 9) == 0)
          cast(COL_BITS'($urandom));
        else
          cast(COL_BITS'($urandom_range(0, (cols == 0) ? 0 : cols - 1)));
      end
      wait_idle();
    end
  endtask

  initial begin
    request.valid      = 1'b0;
    request.operation  = OP_WRITE;
    request.cell_index = '0;
    request.cell_wall  = 1'b0;
    request.column     = '0;
    cfg_write          = 1'b0;
    cfg_index          = CFG_POSE_X;
    cfg_data           = '0;
    view_x = POSE_BITS'(2048); view_y = POSE_BITS'(2048);
    view_angle = '0; view_span = REG_BITS'(256);
    view_cols = REG_BITS'(320); view_rows = REG_BITS'(240); march_limit = REG_BITS'(320);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_view();
    test_wall_hits();
    test_view_extremes();
    test_random_scenes(10, 93);
    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
